// ----- hdl/assert_macros.svh -----
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds in every cycle outside reset
`define E2C_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that trig in one cycle is followed by cons in the next
`define E2C_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/e2cal_pkg.sv -----
// Package: constants, types and the month-length table for the date converter
`default_nettype none

package e2cal_pkg;

   // Calendar epoch and derived counter seeds
   localparam int EPOCH_YEAR    = 1970;
   localparam int YEAR_W        = 13;
   localparam int EPOCH_MOD100  = EPOCH_YEAR % 100;
   localparam int EPOCH_MOD400  = EPOCH_YEAR % 400;

   // Time-of-day divisors
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   // Reciprocal division: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15;
   // the power of two is shifted off, the odd factor is divided by multiply and shift
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
   localparam logic [25:0] DAY_ODD    = 26'd675;
   localparam logic [25:0] HOUR_RECIP = 26'd9321;      // ceil(2^21 / 225)
   localparam logic [25:0] HOUR_ODD   = 26'd225;
   localparam logic [25:0] MIN_RECIP  = 26'd1093;      // ceil(2^14 / 15)
   localparam logic [25:0] MIN_ODD    = 26'd15;
   localparam int DAY_SHIFT  = 35;
   localparam int HOUR_SHIFT = 21;
   localparam int MIN_SHIFT  = 14;

   // Datapath width of the shared subtractor
   localparam int ALU_W = 18;

   // Month indexes, 0-based
   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_APR = 4'd3;
   localparam logic [3:0] MONTH_JUN = 4'd5;
   localparam logic [3:0] MONTH_SEP = 4'd8;
   localparam logic [3:0] MONTH_NOV = 4'd10;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } e2cal_state_type;

   typedef enum logic [2:0] {
      PH_DAY_QUO,
      PH_DAY_REM,
      PH_HOUR_QUO,
      PH_HOUR_REM,
      PH_MIN_QUO,
      PH_MIN_REM
   } e2cal_phase_type;

   // Days in a month, February stretched in leap years
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/epoch_seconds_to_calendar_date.sv -----
// Reciprocal division (one multiplier plus the shared subtractor) splits off days,
// hours, minutes and seconds; year steps then remove whole years and month steps
// whole months, and one output load raises rsp_valid with the result.
// One item in flight: the next transfer is taken the cycle after the result is loaded;
// a result still stalled at the output delays the load.
// Reset (synchronous, active high) returns to idle and drops any pending result.
`default_nettype none

module epoch_seconds_to_calendar_date
   import e2cal_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second
);

   e2cal_state_type state_ff, state_in;
   e2cal_phase_type phase_ff, phase_in;

   logic [31:0]       num_ff, num_in;
   logic [16:0]       rem_ff, rem_in;
   logic [15:0]       days_ff, days_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [6:0]        mod100_ff, mod100_in;
   logic [8:0]        mod400_ff, mod400_in;
   logic [3:0]        month_ff, month_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [5:0]        second_ff, second_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [11:0]       rsp_year_ff, rsp_year_in;
   logic [3:0]        rsp_month_ff, rsp_month_in;
   logic [4:0]        rsp_day_ff, rsp_day_in;
   logic [4:0]        rsp_hour_ff, rsp_hour_in;
   logic [5:0]        rsp_minute_ff, rsp_minute_in;
   logic [5:0]        rsp_second_ff, rsp_second_in;

   logic [ALU_W-1:0]  sub_a, sub_b, sub_diff;
   logic              sub_ge;
   logic              leap;
   logic [24:0]       mul_a;
   logic [25:0]       mul_b;
   logic [50:0]       mul_p;

   // Leap rule from the running residues of the year
   assign leap = (mod400_ff == 9'd0) || ((year_ff[1:0] == 2'd0) && (mod100_ff != 7'd0));

   // Select operands for the shared multiplier: reciprocal, then quotient times the divisor's odd factor
   always_comb begin
      case (phase_ff)
         PH_DAY_QUO: begin
            mul_a = num_ff[31:7];
            mul_b = DAY_RECIP;
         end
         PH_DAY_REM: begin
            mul_a = {9'd0, days_ff};
            mul_b = DAY_ODD;
         end
         PH_HOUR_QUO: begin
            mul_a = {12'd0, rem_ff[16:4]};
            mul_b = HOUR_RECIP;
         end
         PH_HOUR_REM: begin
            mul_a = {20'd0, hour_ff};
            mul_b = HOUR_ODD;
         end
         PH_MIN_QUO: begin
            mul_a = {15'd0, rem_ff[11:2]};
            mul_b = MIN_RECIP;
         end
         default: begin
            mul_a = {19'd0, minute_ff};
            mul_b = MIN_ODD;
         end
      endcase
   end

   assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

   // Select operands for the shared subtractor
   always_comb begin
      sub_a = {2'b00, days_ff};
      sub_b = '0;
      unique case (state_ff)
         ST_DIV: begin
            // Remainders are narrow, so only their low bits are subtracted
            case (phase_ff)
               PH_DAY_REM: begin
                  sub_a = {8'd0, num_ff[16:7]};
                  sub_b = {8'd0, mul_p[9:0]};
               end
               PH_HOUR_REM: begin
                  sub_a = {10'd0, rem_ff[11:4]};
                  sub_b = {10'd0, mul_p[7:0]};
               end
               PH_MIN_REM: begin
                  sub_a = {14'd0, rem_ff[5:2]};
                  sub_b = {14'd0, mul_p[3:0]};
               end
               default: sub_b = '0;
            endcase
         end
         ST_YEAR:  sub_b = leap ? ALU_W'(366) : ALU_W'(365);
         ST_MONTH: sub_b = {13'd0, month_len(month_ff, leap)};
         default:  sub_b = '0;
      endcase
   end

   e2cal_subtract u_sub (
      .opa  (sub_a),
      .opb  (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      days_in       = days_ff;
      year_in       = year_ff;
      mod100_in     = mod100_ff;
      mod400_in     = mod400_ff;
      month_in      = month_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;

      // Drop the result once it has been transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in    = req_epoch_seconds;
               phase_in  = PH_DAY_QUO;
               year_in   = YEAR_W'(EPOCH_YEAR);
               mod100_in = 7'(EPOCH_MOD100);
               mod400_in = 9'(EPOCH_MOD400);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // Split off days, hours, minutes and seconds, one product per cycle
            case (phase_ff)
               PH_DAY_QUO: begin
                  days_in  = mul_p[DAY_SHIFT+15:DAY_SHIFT];
                  phase_in = PH_DAY_REM;
               end
               PH_DAY_REM: begin
                  rem_in   = {sub_diff[9:0], num_ff[6:0]};
                  phase_in = PH_HOUR_QUO;
               end
               PH_HOUR_QUO: begin
                  hour_in  = mul_p[HOUR_SHIFT+4:HOUR_SHIFT];
                  phase_in = PH_HOUR_REM;
               end
               PH_HOUR_REM: begin
                  rem_in   = {5'd0, sub_diff[7:0], rem_ff[3:0]};
                  phase_in = PH_MIN_QUO;
               end
               PH_MIN_QUO: begin
                  minute_in = mul_p[MIN_SHIFT+5:MIN_SHIFT];
                  phase_in  = PH_MIN_REM;
               end
               default: begin
                  second_in = {sub_diff[3:0], rem_ff[1:0]};
                  state_in  = ST_YEAR;
               end
            endcase
         end
         ST_YEAR: begin
            // Remove one whole year, or move on to months
            if (sub_ge) begin
               days_in   = sub_diff[15:0];
               year_in   = year_ff + YEAR_W'(1);
               mod100_in = (mod100_ff == 7'd99)  ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end else begin
               month_in = MONTH_JAN;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // Remove one whole month; December takes the rest
            if (month_ff == MONTH_DEC || !sub_ge) begin
               state_in = ST_DONE;
            end else begin
               days_in  = sub_diff[15:0];
               month_in = month_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = year_ff[11:0];
               rsp_month_in  = month_ff + 4'd1;
               rsp_day_in    = days_ff[4:0] + 5'd1;
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
               rsp_second_in = second_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance datapath and result registers
   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      days_ff       <= days_in;
      year_ff       <= year_in;
      mod100_ff     <= mod100_in;
      mod400_ff     <= mod400_in;
      month_ff      <= month_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_hour_ff;
   assign rsp_minute = rsp_minute_ff;
   assign rsp_second = rsp_second_ff;

endmodule

`default_nettype wire

// ----- hdl/e2cal_subtract.sv -----
// Shared subtract and compare unit used by the remainder, year and month steps of the converter
`default_nettype none

module e2cal_subtract
   import e2cal_pkg::*;
(
   input  wire logic [ALU_W-1:0] opa,
   input  wire logic [ALU_W-1:0] opb,
   output logic      [ALU_W-1:0] diff,
   output logic                  ge
);

   logic [ALU_W:0] full;

   // Subtract with one guard bit; a clear borrow means opa >= opb
   assign full = {1'b0, opa} - {1'b0, opb};
   assign diff = full[ALU_W-1:0];
   assign ge   = ~full[ALU_W];

endmodule

`default_nettype wire

// ----- hdl/e2cal_checker.sv -----
// Port-level checker for the date converter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module e2cal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [31:0] req_epoch_seconds,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [11:0] rsp_year,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic [4:0]  rsp_hour,
   input wire logic [5:0]  rsp_minute,
   input wire logic [5:0]  rsp_second
);

   logic unused_ok;
   logic date_ok;
   logic time_ok;
   assign unused_ok = ^{req_epoch_seconds, rsp_year};

   // Calendar and clock ranges of the result fields
   assign date_ok = (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day >= 5'd1);
   assign time_ok = (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59) && (rsp_second <= 6'd59);

   // A stalled result stays offered
   `E2C_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // An input transfer keeps the converter busy in the next cycle
   `E2C_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // Date fields stay in calendar range
   `E2C_ASSERT_ALWAYS(a_date_range, clock, reset, !rsp_valid || date_ok)
   // Time fields stay in clock range
   `E2C_ASSERT_ALWAYS(a_time_range, clock, reset, !rsp_valid || time_ok)

endmodule

bind epoch_seconds_to_calendar_date e2cal_checker u_e2cal_checker (.*);

`default_nettype wire
